// ----- rtl/line_sensor_normalize_position_macros.svh -----
// assertion macros for the line sensor normalisation block
// used by the top level only, expects signals named clock and reset in scope
`ifndef LINE_SENSOR_NORMALIZE_POSITION_MACROS_SVH
`define LINE_SENSOR_NORMALIZE_POSITION_MACROS_SVH

// same-cycle implication, disabled during reset
`define LSNP_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LSNP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/lsnp_pkg.sv -----
// shared constants, types and the channel weight table for the line sensor block
// no dependencies
package lsnp_pkg;

   localparam int CHANNELS    = 8;
   localparam int CH_BITS     = 3;
   localparam int SAMPLE_BITS = 12;
   localparam int OP_BITS     = 2;

   localparam int LEVEL_BITS  = 7;
   localparam int POS_BITS    = 10;
   localparam int BITS_WIDTH  = 8;
   localparam int MEAN_BITS   = 7;
   localparam int SUM_BITS    = 10;
   localparam int CNT_BITS    = 10;
   localparam int WSUM_BITS   = 20;
   localparam int WEIGHT_BITS = 10;

   localparam logic [LEVEL_BITS-1:0] LEVEL_FULL    = 7'd100;
   localparam logic [LEVEL_BITS-1:0] BIT_THRESHOLD = 7'd49;
   localparam logic [LEVEL_BITS-1:0] POS_THRESHOLD = 7'd10;

   // divider: quotient width and per-use quotient bit counts
   localparam int QUOT_BITS = 9;
   localparam int QCNT_BITS = 4;
   localparam logic [QCNT_BITS-1:0] LEVEL_QBITS = 4'd7;
   localparam logic [QCNT_BITS-1:0] POS_QBITS   = 4'd9;

   typedef enum logic [OP_BITS-1:0] {
      OP_MEASURE   = 2'd0,
      OP_CAL_RESET = 2'd1,
      OP_CALIBRATE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_DIV,
      S_ACC,
      S_POS,
      S_PDIV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [QCNT_BITS-1:0] qbits;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // centroid weight of each channel
   function automatic logic signed [WEIGHT_BITS-1:0] chan_weight(input logic [CH_BITS-1:0] ch);
      logic signed [WEIGHT_BITS-1:0] w;
      case (ch)
         3'd0: w = -10'sd350;
         3'd1: w = -10'sd250;
         3'd2: w = -10'sd150;
         3'd3: w = -10'sd50;
         3'd4: w = 10'sd50;
         3'd5: w = 10'sd150;
         3'd6: w = 10'sd250;
         3'd7: w = 10'sd350;
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/lsnp_if.sv -----
// channel interfaces of the line sensor block: frame request, result and register write
// depends on lsnp_pkg
interface lsnp_req_if #(parameter int SAMPLE_BITS = lsnp_pkg::SAMPLE_BITS);
   logic                          valid;
   logic                          ready;
   logic [lsnp_pkg::OP_BITS-1:0]  op;
   logic [SAMPLE_BITS-1:0]        sample_ch0;
   logic [SAMPLE_BITS-1:0]        sample_ch1;
   logic [SAMPLE_BITS-1:0]        sample_ch2;
   logic [SAMPLE_BITS-1:0]        sample_ch3;
   logic [SAMPLE_BITS-1:0]        sample_ch4;
   logic [SAMPLE_BITS-1:0]        sample_ch5;
   logic [SAMPLE_BITS-1:0]        sample_ch6;
   logic [SAMPLE_BITS-1:0]        sample_ch7;

   modport source (output valid, op, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                   sample_ch4, sample_ch5, sample_ch6, sample_ch7, input ready);
   modport sink   (input valid, op, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                   sample_ch4, sample_ch5, sample_ch6, sample_ch7, output ready);
endinterface

interface lsnp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lsnp_pkg::POS_BITS-1:0] line_position;
   logic [lsnp_pkg::BITS_WIDTH-1:0]      line_bits;
   logic [lsnp_pkg::MEAN_BITS-1:0]       mean_level;

   modport source (output valid, line_position, line_bits, mean_level, input ready);
   modport sink   (input valid, line_position, line_bits, mean_level, output ready);
endinterface

interface lsnp_csr_if;
   logic valid;
   logic ready;
   logic white_line_mode;

   modport source (output valid, white_line_mode, input ready);
   modport sink   (input valid, white_line_mode, output ready);
endinterface

// ----- rtl/line_sensor_normalize_position.sv -----
// top level of the eight-channel line sensor normalisation and centroid block
// depends on lsnp_pkg, lsnp_if, lsnp_div and the assertion macro header
//
// Takes one frame transaction at a time. Reset-calibration, calibrate and the unused
// op code complete in the cycle they are taken; the block is ready again next cycle.
// A measure runs the channels one after another through a single shared divider that
// yields one quotient bit per cycle; a channel whose range is empty or a single point
// skips the divider. The centroid division follows, skipped when no channel counts
// toward it, and the result register is loaded once the output register is free. The
// result sits in an output register until taken; a following frame is accepted
// meanwhile.
`include "line_sensor_normalize_position_macros.svh"

module line_sensor_normalize_position #(
   parameter int SAMPLE_BITS = lsnp_pkg::SAMPLE_BITS
) (
   input logic         clock,
   input logic         reset,
   lsnp_req_if.sink    req_chan,
   lsnp_rsp_if.source  rsp_chan,
   lsnp_csr_if.sink    csr_chan
);

   localparam int NUM_BITS      = SAMPLE_BITS + lsnp_pkg::LEVEL_BITS;
   localparam int MAG_BITS      = lsnp_pkg::WSUM_BITS - 1;
   localparam int DIVIDEND_BITS = (NUM_BITS > MAG_BITS) ? NUM_BITS : MAG_BITS;
   localparam int DIVISOR_BITS  = (SAMPLE_BITS > lsnp_pkg::CNT_BITS) ?
                                  SAMPLE_BITS : lsnp_pkg::CNT_BITS;
   localparam logic [lsnp_pkg::CH_BITS-1:0] CH_LAST =
      lsnp_pkg::CH_BITS'(lsnp_pkg::CHANNELS - 1);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONES = '1;

   lsnp_pkg::state_type                     state_ff, state_in;
   logic [lsnp_pkg::CH_BITS-1:0]            ch_ff;
   logic [SAMPLE_BITS-1:0]                  min_ff [lsnp_pkg::CHANNELS];
   logic [SAMPLE_BITS-1:0]                  max_ff [lsnp_pkg::CHANNELS];
   logic [SAMPLE_BITS-1:0]                  smp_ff [lsnp_pkg::CHANNELS];
   logic [SAMPLE_BITS-1:0]                  smp_in [lsnp_pkg::CHANNELS];
   logic                                    white_ff;
   logic [lsnp_pkg::LEVEL_BITS-1:0]         lvl_ff;
   logic [lsnp_pkg::SUM_BITS-1:0]           sum_ff;
   logic [lsnp_pkg::BITS_WIDTH-1:0]         bits_ff;
   logic [lsnp_pkg::CNT_BITS-1:0]           cnt_ff;
   logic signed [lsnp_pkg::WSUM_BITS-1:0]   wsum_ff;
   logic signed [lsnp_pkg::POS_BITS-1:0]    pos_ff;
   logic                                    rsp_valid_ff;
   logic signed [lsnp_pkg::POS_BITS-1:0]    rsp_pos_ff;
   logic [lsnp_pkg::BITS_WIDTH-1:0]         rsp_bits_ff;
   logic [lsnp_pkg::MEAN_BITS-1:0]          rsp_mean_ff;

   logic                                    accept;
   logic                                    out_free;
   logic [SAMPLE_BITS-1:0]                  cur_smp, cur_lo, cur_hi, clamped, span;
   logic                                    degen;
   logic [NUM_BITS-1:0]                     num_lvl;
   logic [lsnp_pkg::WSUM_BITS-1:0]          wsum_neg;
   logic [MAG_BITS-1:0]                     wsum_mag;
   logic [lsnp_pkg::LEVEL_BITS-1:0]         q_lvl, level;
   logic signed [lsnp_pkg::WSUM_BITS-1:0]   wprod;
   logic [DIVIDEND_BITS-1:0]                div_dividend;
   logic [DIVISOR_BITS-1:0]                 div_divisor;
   logic [lsnp_pkg::QUOT_BITS-1:0]          div_quot;
   lsnp_pkg::div_ctrl_type                  div_ctrl;
   lsnp_pkg::div_stat_type                  div_stat;

   // frame samples as an array
   assign smp_in[0] = req_chan.sample_ch0;
   assign smp_in[1] = req_chan.sample_ch1;
   assign smp_in[2] = req_chan.sample_ch2;
   assign smp_in[3] = req_chan.sample_ch3;
   assign smp_in[4] = req_chan.sample_ch4;
   assign smp_in[5] = req_chan.sample_ch5;
   assign smp_in[6] = req_chan.sample_ch6;
   assign smp_in[7] = req_chan.sample_ch7;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // per-channel clamp and scale numerator
   assign cur_smp = smp_ff[ch_ff];
   assign cur_lo  = min_ff[ch_ff];
   assign cur_hi  = max_ff[ch_ff];
   assign degen   = cur_hi <= cur_lo;
   assign clamped = (cur_smp < cur_lo) ? cur_lo : ((cur_smp > cur_hi) ? cur_hi : cur_smp);
   assign span    = cur_hi - cur_lo;
   assign num_lvl = NUM_BITS'(clamped - cur_lo) * NUM_BITS'(lsnp_pkg::LEVEL_FULL);

   // centroid numerator magnitude
   assign wsum_neg = -wsum_ff;
   assign wsum_mag = wsum_ff[lsnp_pkg::WSUM_BITS-1] ? wsum_neg[MAG_BITS-1:0]
                                                    : wsum_ff[MAG_BITS-1:0];

   // level from quotient, inverted for white line
   assign q_lvl = div_quot[lsnp_pkg::LEVEL_BITS-1:0];
   assign level = white_ff ? (lsnp_pkg::LEVEL_FULL - q_lvl) : q_lvl;
   assign wprod = lsnp_pkg::WSUM_BITS'($signed({1'b0, lvl_ff})) *
                  lsnp_pkg::WSUM_BITS'(lsnp_pkg::chan_weight(ch_ff));

   // divider operand select
   always_comb begin
      if (state_ff == lsnp_pkg::S_POS) begin
         div_dividend = DIVIDEND_BITS'(wsum_mag);
         div_divisor  = DIVISOR_BITS'(cnt_ff);
      end else begin
         div_dividend = DIVIDEND_BITS'(num_lvl);
         div_divisor  = DIVISOR_BITS'(span);
      end
   end

   lsnp_div #(
      .DIVIDEND_BITS (DIVIDEND_BITS),
      .DIVISOR_BITS  (DIVISOR_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .stat     (div_stat),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lsnp_pkg::S_IDLE: begin
            if (accept && req_chan.op == lsnp_pkg::OP_MEASURE) begin
               state_in = lsnp_pkg::S_PREP;
            end
         end
         lsnp_pkg::S_PREP: begin
            state_in = degen ? lsnp_pkg::S_ACC : lsnp_pkg::S_DIV;
         end
         lsnp_pkg::S_DIV: begin
            if (div_stat.done) begin
               state_in = lsnp_pkg::S_ACC;
            end
         end
         lsnp_pkg::S_ACC: begin
            state_in = (ch_ff == CH_LAST) ? lsnp_pkg::S_POS : lsnp_pkg::S_PREP;
         end
         lsnp_pkg::S_POS: begin
            state_in = (cnt_ff == '0) ? lsnp_pkg::S_DONE : lsnp_pkg::S_PDIV;
         end
         lsnp_pkg::S_PDIV: begin
            if (div_stat.done) begin
               state_in = lsnp_pkg::S_DONE;
            end
         end
         lsnp_pkg::S_DONE: begin
            if (out_free) begin
               state_in = lsnp_pkg::S_IDLE;
            end
         end
         default: state_in = lsnp_pkg::S_IDLE;
      endcase
   end

   // handshake and divider control
   always_comb begin
      req_chan.ready = state_ff == lsnp_pkg::S_IDLE;
      csr_chan.ready = 1'b1;
      div_ctrl.start = 1'b0;
      div_ctrl.qbits = lsnp_pkg::LEVEL_QBITS;
      case (state_ff)
         lsnp_pkg::S_PREP: begin
            div_ctrl.start = !degen;
         end
         lsnp_pkg::S_POS: begin
            div_ctrl.start = cnt_ff != '0;
            div_ctrl.qbits = lsnp_pkg::POS_QBITS;
         end
         default: begin
            div_ctrl.start = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsnp_pkg::S_IDLE;
         white_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_chan.valid && csr_chan.ready) begin
            white_ff <= csr_chan.white_line_mode;
         end
         if (state_ff == lsnp_pkg::S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // calibration range per channel
   always_ff @(posedge clock) begin
      for (int i = 0; i < lsnp_pkg::CHANNELS; i++) begin
         if (reset || (accept && req_chan.op == lsnp_pkg::OP_CAL_RESET)) begin
            min_ff[i] <= SAMPLE_ONES;
            max_ff[i] <= '0;
         end else if (accept && req_chan.op == lsnp_pkg::OP_CALIBRATE) begin
            if (smp_in[i] < min_ff[i]) begin
               min_ff[i] <= smp_in[i];
            end
            if (smp_in[i] > max_ff[i]) begin
               max_ff[i] <= smp_in[i];
            end
         end
      end
   end

   // measure datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         lsnp_pkg::S_IDLE: begin
            if (accept) begin
               smp_ff  <= smp_in;
               ch_ff   <= '0;
               sum_ff  <= '0;
               bits_ff <= '0;
               cnt_ff  <= '0;
               wsum_ff <= '0;
            end
         end
         lsnp_pkg::S_PREP: begin
            if (degen) begin
               lvl_ff <= '0;
            end
         end
         lsnp_pkg::S_DIV: begin
            if (div_stat.done) begin
               lvl_ff <= level;
            end
         end
         lsnp_pkg::S_ACC: begin
            sum_ff <= sum_ff + lsnp_pkg::SUM_BITS'(lvl_ff);
            if (lvl_ff > lsnp_pkg::BIT_THRESHOLD) begin
               bits_ff[CH_LAST - ch_ff] <= 1'b1;
            end
            if (lvl_ff > lsnp_pkg::POS_THRESHOLD) begin
               cnt_ff  <= cnt_ff + lsnp_pkg::CNT_BITS'(lvl_ff);
               wsum_ff <= wsum_ff + wprod;
            end
            ch_ff <= ch_ff + 1'b1;
         end
         lsnp_pkg::S_POS: begin
            pos_ff <= '0;
         end
         lsnp_pkg::S_PDIV: begin
            if (div_stat.done) begin
               pos_ff <= wsum_ff[lsnp_pkg::WSUM_BITS-1] ? -lsnp_pkg::POS_BITS'(div_quot)
                                                        : lsnp_pkg::POS_BITS'(div_quot);
            end
         end
         lsnp_pkg::S_DONE: begin
            if (out_free) begin
               rsp_pos_ff  <= pos_ff;
               rsp_bits_ff <= bits_ff;
               rsp_mean_ff <= sum_ff[lsnp_pkg::SUM_BITS-1:3];
            end
         end
         default: begin
            lvl_ff <= lvl_ff;
         end
      endcase
   end

   // result channel
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.line_position = rsp_pos_ff;
   assign rsp_chan.line_bits     = rsp_bits_ff;
   assign rsp_chan.mean_level    = rsp_mean_ff;

   // checks
   `LSNP_ASSERT_IMPLIES(a_div_start_idle, div_ctrl.start, !div_stat.busy, "divider restarted while busy")
   `LSNP_ASSERT_IMPLIES(a_div_done_wait, div_stat.done, state_ff == lsnp_pkg::S_DIV || state_ff == lsnp_pkg::S_PDIV, "divider finished outside a wait state")
   `LSNP_ASSERT_NEXT(a_result_hold, state_ff == lsnp_pkg::S_DONE && rsp_valid_ff && !rsp_chan.ready, state_ff == lsnp_pkg::S_DONE, "result overwrote an untaken transaction")
   `LSNP_ASSERT_IMPLIES(a_mean_range, rsp_valid_ff, rsp_mean_ff <= lsnp_pkg::LEVEL_FULL, "mean level above full scale")

endmodule

// ----- rtl/lsnp_div.sv -----
// shared restoring divider, one quotient bit per cycle, quotient known to fit qbits bits
// depends on lsnp_pkg
module lsnp_div #(
   parameter int DIVIDEND_BITS = 23,
   parameter int DIVISOR_BITS  = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lsnp_pkg::div_ctrl_type            ctrl,
   output lsnp_pkg::div_stat_type            stat,
   input  logic [DIVIDEND_BITS-1:0]          dividend,
   input  logic [DIVISOR_BITS-1:0]           divisor,
   output logic [lsnp_pkg::QUOT_BITS-1:0]    quotient
);

   localparam int SW = DIVISOR_BITS + lsnp_pkg::QUOT_BITS - 1;
   localparam int CW = (DIVIDEND_BITS > SW) ? DIVIDEND_BITS : SW;

   logic [DIVIDEND_BITS-1:0]           rem_ff;
   logic [SW-1:0]                      dsh_ff;
   logic [lsnp_pkg::QUOT_BITS-1:0]     quot_ff;
   logic [lsnp_pkg::QCNT_BITS-1:0]     cnt_ff;
   logic                               done_ff;
   logic                               ge;
   logic [DIVIDEND_BITS-1:0]           diff;

   // trial subtraction of the aligned divisor
   assign ge   = CW'(rem_ff) >= CW'(dsh_ff);
   assign diff = rem_ff - DIVIDEND_BITS'(dsh_ff);

   // step counter and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (ctrl.start) begin
         cnt_ff  <= ctrl.qbits;
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_ff - 1'b1;
         done_ff <= (cnt_ff == lsnp_pkg::QCNT_BITS'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   // remainder, aligned divisor and quotient
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         rem_ff  <= dividend;
         dsh_ff  <= SW'(divisor) << (ctrl.qbits - 1'b1);
         quot_ff <= '0;
      end else if (cnt_ff != '0) begin
         if (ge) begin
            rem_ff <= diff;
         end
         dsh_ff  <= dsh_ff >> 1;
         quot_ff <= {quot_ff[lsnp_pkg::QUOT_BITS-2:0], ge};
      end
   end

   assign stat.busy = cnt_ff != '0;
   assign stat.done = done_ff;
   assign quotient  = quot_ff;

endmodule

// ----- sim/tb_line_sensor_normalize_position.sv -----
// self-checking testbench for the eight-channel line sensor normalisation block
// depends on lsnp_pkg, lsnp_if and the line_sensor_normalize_position top level
// drives frames and register writes, predicts every reading and checks it on arrival
module tb_line_sensor_normalize_position;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [lsnp_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;

   localparam int LEVEL_TOP     = lsnp_pkg::LEVEL_FULL;
   localparam int LINE_LEVEL    = lsnp_pkg::BIT_THRESHOLD;
   localparam int CENTROID_FLOOR = lsnp_pkg::POS_THRESHOLD;
   localparam int CENTROID_WEIGHT [lsnp_pkg::CHANNELS] =
      '{-350, -250, -150, -50, 50, 150, 250, 350};

   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_AFTER    = 60;
   localparam int HOLD_CYCLES   = 500;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 100;

   typedef logic [lsnp_pkg::SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic [lsnp_pkg::OP_BITS-1:0]                                op;
      logic [lsnp_pkg::CHANNELS-1:0][lsnp_pkg::SAMPLE_BITS-1:0]    sample;
   } frame_type;

   typedef struct packed {
      logic signed [lsnp_pkg::POS_BITS-1:0] line_position;
      logic [lsnp_pkg::BITS_WIDTH-1:0]      line_bits;
      logic [lsnp_pkg::MEAN_BITS-1:0]       mean_level;
   } reading_type;

   // calibration state, line mode and the readings still owed by the block
   class reading_scoreboard;
      int          ch_min [lsnp_pkg::CHANNELS];
      int          ch_max [lsnp_pkg::CHANNELS];
      bit          white_line;
      reading_type pending_readings [$];
      int          errors;

      function new();
         clear_calibration();
         white_line = 1'b0;
         errors     = 0;
      endfunction

      function void clear_calibration();
         for (int ch = 0; ch < lsnp_pkg::CHANNELS; ch++) begin
            ch_min[ch] = (1 << lsnp_pkg::SAMPLE_BITS) - 1;
            ch_max[ch] = 0;
         end
      endfunction

      // normalise, threshold and take the weighted centroid of one frame
      function reading_type compute_reading(frame_type f);
         reading_type r;
         int          level;
         int          lo;
         int          hi;
         int          v;
         int          sum_all;
         int          cnt;
         int          wsum;
         int          pos;
         logic [lsnp_pkg::BITS_WIDTH-1:0] bits;
         sum_all = 0;
         cnt     = 0;
         wsum    = 0;
         pos     = 0;
         bits    = '0;
         for (int ch = 0; ch < lsnp_pkg::CHANNELS; ch++) begin
            lo = ch_min[ch];
            hi = ch_max[ch];
            v  = f.sample[ch];
            // empty or single-point range reads as zero in both modes
            if (hi <= lo) begin
               level = 0;
            end else begin
               if (v < lo) v = lo;
               else if (v > hi) v = hi;
               level = ((v - lo) * LEVEL_TOP) / (hi - lo);
               if (white_line) level = LEVEL_TOP - level;
            end
            sum_all += level;
            if (level > LINE_LEVEL) bits[lsnp_pkg::BITS_WIDTH-1-ch] = 1'b1;
            if (level > CENTROID_FLOOR) begin
               cnt  += level;
               wsum += level * CENTROID_WEIGHT[ch];
            end
         end
         // signed division truncates toward zero
         if (cnt != 0) pos = wsum / cnt;
         r.line_position = lsnp_pkg::POS_BITS'(pos);
         r.line_bits     = bits;
         r.mean_level    = lsnp_pkg::MEAN_BITS'(sum_all / lsnp_pkg::CHANNELS);
         return r;
      endfunction

      // apply an accepted frame transaction to the calibration state or, for a measure, queue its predicted reading
      function void note_frame(frame_type f);
         case (f.op)
            lsnp_pkg::OP_MEASURE: begin
               pending_readings.push_back(compute_reading(f));
            end
            lsnp_pkg::OP_CAL_RESET: begin
               clear_calibration();
            end
            lsnp_pkg::OP_CALIBRATE: begin
               for (int ch = 0; ch < lsnp_pkg::CHANNELS; ch++) begin
                  if (int'(f.sample[ch]) < ch_min[ch]) ch_min[ch] = f.sample[ch];
                  if (int'(f.sample[ch]) > ch_max[ch]) ch_max[ch] = f.sample[ch];
               end
            end
            default: begin
               // unused op code leaves everything alone
            end
         endcase
      endfunction

      // compare an accepted result transaction with the oldest prediction
      function void check_result(reading_type got);
         reading_type want;
         if (pending_readings.size() == 0) begin
            $error("reading with none expected: line_position %0d line_bits %02h mean_level %0d",
                   got.line_position, got.line_bits, got.mean_level);
            errors++;
            return;
         end
         want = pending_readings.pop_front();
         if (got.line_position !== want.line_position) begin
            $error("line_position expected %0d actual %0d", want.line_position,
                   got.line_position);
            errors++;
         end
         if (got.line_bits !== want.line_bits) begin
            $error("line_bits expected %02h actual %02h", want.line_bits, got.line_bits);
            errors++;
         end
         if (got.mean_level !== want.mean_level) begin
            $error("mean_level expected %0d actual %0d", want.mean_level, got.mean_level);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   lsnp_req_if req_chan ();
   lsnp_rsp_if rsp_chan ();
   lsnp_csr_if csr_chan ();

   line_sensor_normalize_position dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   reading_scoreboard sb;
   bit                idle_on = 1'b1;
   int unsigned       cycle_count = 0;
   int unsigned       readings_taken = 0;
   int unsigned       stall_left = 0;
   int unsigned       hold_left = 0;
   reading_type       taken;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("line_sensor_normalize_position: mismatch");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off, check each transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            taken.line_position = rsp_chan.line_position;
            taken.line_bits     = rsp_chan.line_bits;
            taken.mean_level    = rsp_chan.mean_level;
            sb.check_result(taken);
            readings_taken++;
            stall_left = idle_on ? $urandom_range(0, 7) : 0;
            if (readings_taken == HOLD_AFTER) hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // sample with weight on the extremes and on the ends of the scale
   function automatic sample_type rand_sample();
      case ($urandom_range(0, 3))
         0:       return sample_type'($urandom_range(0, 4095));
         1:       return $urandom_range(0, 1) ? '1 : '0;
         2:       return sample_type'($urandom_range(0, 400));
         default: return sample_type'($urandom_range(3700, 4095));
      endcase
   endfunction

   function automatic frame_type random_frame(logic [lsnp_pkg::OP_BITS-1:0] op);
      frame_type f;
      f.op = op;
      for (int ch = 0; ch < lsnp_pkg::CHANNELS; ch++) f.sample[ch] = rand_sample();
      return f;
   endfunction

   function automatic frame_type uniform_frame(logic [lsnp_pkg::OP_BITS-1:0] op,
                                               sample_type value);
      frame_type f;
      f.op = op;
      for (int ch = 0; ch < lsnp_pkg::CHANNELS; ch++) f.sample[ch] = value;
      return f;
   endfunction

   // offer one frame transaction after a random gap and wait for acceptance
   task automatic send_frame(input frame_type f);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.op         <= f.op;
      req_chan.sample_ch0 <= f.sample[0];
      req_chan.sample_ch1 <= f.sample[1];
      req_chan.sample_ch2 <= f.sample[2];
      req_chan.sample_ch3 <= f.sample[3];
      req_chan.sample_ch4 <= f.sample[4];
      req_chan.sample_ch5 <= f.sample[5];
      req_chan.sample_ch6 <= f.sample[6];
      req_chan.sample_ch7 <= f.sample[7];
      do @(posedge clock); while (!req_chan.ready);
      sb.note_frame(f);
   endtask

   // stop offering, wait for every reading and let the block settle
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (sb.pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // line mode register write while the block is idle
   task automatic write_mode(input bit mode);
      drain();
      csr_chan.valid           <= 1'b1;
      csr_chan.white_line_mode <= mode;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      sb.white_line = mode;
   endtask

   // stimulus
   initial begin
      frame_type   f;
      int unsigned counted;
      int unsigned pick;
      int unsigned n;

      sb = new();
      reset                    <= 1'b1;
      req_chan.valid           <= 1'b0;
      req_chan.op              <= lsnp_pkg::OP_MEASURE;
      req_chan.sample_ch0      <= '0;
      req_chan.sample_ch1      <= '0;
      req_chan.sample_ch2      <= '0;
      req_chan.sample_ch3      <= '0;
      req_chan.sample_ch4      <= '0;
      req_chan.sample_ch5      <= '0;
      req_chan.sample_ch6      <= '0;
      req_chan.sample_ch7      <= '0;
      csr_chan.valid           <= 1'b0;
      csr_chan.white_line_mode <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // dark-line mode, starting from empty calibration
      write_mode(1'b0);
      send_frame(uniform_frame(lsnp_pkg::OP_MEASURE, 12'd2048));
      send_frame(random_frame(OP_UNUSED));
      send_frame(uniform_frame(lsnp_pkg::OP_CALIBRATE, '0));
      send_frame(uniform_frame(lsnp_pkg::OP_MEASURE, '0));
      send_frame(uniform_frame(lsnp_pkg::OP_CALIBRATE, '1));
      send_frame(uniform_frame(lsnp_pkg::OP_MEASURE, '0));
      send_frame(uniform_frame(lsnp_pkg::OP_MEASURE, '1));
      f = uniform_frame(lsnp_pkg::OP_MEASURE, '0);
      f.sample[0] = '1;
      send_frame(f);
      f = uniform_frame(lsnp_pkg::OP_MEASURE, '0);
      f.sample[7] = '1;
      send_frame(f);
      f = uniform_frame(lsnp_pkg::OP_MEASURE, 12'hAAA);
      for (int ch = 1; ch < lsnp_pkg::CHANNELS; ch += 2) f.sample[ch] = 12'h555;
      send_frame(f);
      for (int ch = 0; ch < lsnp_pkg::CHANNELS; ch++) f.sample[ch] = sample_type'(ch * 585);
      send_frame(f);
      // levels just either side of the centroid and line thresholds
      f.sample[0] = 12'd410;
      f.sample[1] = 12'd451;
      f.sample[2] = 12'd2007;
      f.sample[3] = 12'd2048;
      f.sample[4] = 12'd451;
      f.sample[5] = 12'd410;
      f.sample[6] = 12'd2048;
      f.sample[7] = '0;
      send_frame(f);
      send_frame(random_frame(lsnp_pkg::OP_CAL_RESET));
      send_frame(uniform_frame(lsnp_pkg::OP_MEASURE, '1));
      send_frame(uniform_frame(lsnp_pkg::OP_CALIBRATE, 12'd1000));
      send_frame(uniform_frame(lsnp_pkg::OP_MEASURE, 12'd1000));
      send_frame(uniform_frame(lsnp_pkg::OP_CALIBRATE, 12'd3000));
      // clamping below and above a narrow range
      f = uniform_frame(lsnp_pkg::OP_MEASURE, '0);
      f.sample[1] = '1;
      f.sample[2] = 12'd999;
      f.sample[3] = 12'd3001;
      f.sample[4] = 12'd1500;
      f.sample[5] = 12'd2500;
      f.sample[6] = 12'd2999;
      f.sample[7] = 12'd1001;
      send_frame(f);

      // white-line mode
      write_mode(1'b1);
      send_frame(uniform_frame(lsnp_pkg::OP_MEASURE, '1));
      send_frame(uniform_frame(lsnp_pkg::OP_MEASURE, '0));
      send_frame(f);
      send_frame(uniform_frame(lsnp_pkg::OP_CAL_RESET, '1));
      send_frame(uniform_frame(lsnp_pkg::OP_MEASURE, 12'd2048));
      send_frame(uniform_frame(lsnp_pkg::OP_CALIBRATE, '0));
      send_frame(uniform_frame(lsnp_pkg::OP_CALIBRATE, '1));
      for (int ch = 0; ch < lsnp_pkg::CHANNELS; ch++) f.sample[ch] = sample_type'(ch * 585);
      send_frame(f);

      // random phases: mostly measures, with recalibration runs and noise
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_on = (phase != 2);
         write_mode(bit'($urandom_range(0, 1)));
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               send_frame(random_frame(lsnp_pkg::OP_CAL_RESET));
               n = $urandom_range(1, 4);
               repeat (n) send_frame(random_frame(lsnp_pkg::OP_CALIBRATE));
               counted += n + 1;
            end else if (pick < 10) begin
               send_frame(random_frame(OP_UNUSED));
            end else if (pick < 14) begin
               send_frame(random_frame(lsnp_pkg::OP_CALIBRATE));
               counted++;
            end else begin
               send_frame(random_frame(lsnp_pkg::OP_MEASURE));
               counted++;
            end
         end
      end

      drain();
      if (sb.errors == 0 && sb.pending_readings.size() == 0) begin
         $display("line_sensor_normalize_position: match");
      end else begin
         $display("line_sensor_normalize_position: mismatch");
      end
      $finish;
   end

endmodule
